// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the lag-1 autocorrelation block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lac_pkg.sv -----
// Shared types, constants and width helpers for the lag-1 autocorrelation block.
// Depends on nothing; used by every module of the block.
package lac_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_W        = 16;
    localparam int FRAC_BITS       = 15;
    localparam int QUOT_BITS       = 17;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_FLAT = 2'd2,
        ST_OVER = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_WRAP,
        BK_SQ,
        BK_MQ,
        BK_MP,
        BK_CHK,
        BK_DEN,
        BK_NUM,
        BK_DIV,
        BK_OUT
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_flags;

    // Sample counter width
    function automatic int cnt_w(input int max_samples);
        return $clog2(max_samples + 1);
    endfunction

    // Running sum of samples, signed
    function automatic int sum_w(input int k);
        return k + SAMPLE_W;
    endfunction

    // Running sum of squares, unsigned
    function automatic int sq_w(input int k);
        return k + 2 * SAMPLE_W - 2;
    endfunction

    // Running sum of neighbour products, signed
    function automatic int prod_w(input int k);
        return k + 2 * SAMPLE_W - 1;
    endfunction

    // Numerator and denominator terms before scaling, signed
    function automatic int wide_w(input int k);
        return 2 * k + 2 * SAMPLE_W;
    endfunction

    // Scaled dividend and shifted divisor
    function automatic int div_w(input int k);
        return 3 * k + 2 * SAMPLE_W - 1 + FRAC_BITS + 1;
    endfunction

    // Series snapshot handed from front to back
    function automatic int snap_w(input int k);
        return 1 + k + 2 * SAMPLE_W + prod_w(k) + sq_w(k) + sum_w(k);
    endfunction

endpackage

// ----- hw/rtl/circular_lag1_autocorrelation.sv -----
// Throughput: one sample per cycle; o_stall rises only while two finished series wait.
// After the last sample, the result is worked out by the shared shift-add multiplier
// (one multiplier bit per cycle) and the 17-step divider.
// Reset: synchronous, active low; clears the sums, the queue and the output valid flag.
// No clearing pass is needed: the block takes samples in the first cycle after reset.
`include "assert_macros.svh"

module circular_lag1_autocorrelation #(
    parameter int MAX_SAMPLES = lac_pkg::MAX_SAMPLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_sample,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_autocorrelation,
    output logic [1:0]         o_status
);

    localparam int SNAP_W = lac_pkg::snap_w(lac_pkg::cnt_w(MAX_SAMPLES));

    lac_pkg::t_queue_flags w_qflags;
    logic                  w_in_acc;
    logic                  w_push;
    logic                  w_pop;
    logic [SNAP_W-1:0]     w_snap_in;
    logic [SNAP_W-1:0]     w_snap_out;

    // Stall the input only while the queue of finished series is full
    assign o_stall  = w_qflags.full;
    assign w_in_acc = i_valid && !o_stall;

    lac_front #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(w_in_acc),
        .i_sample(i_sample),
        .i_last  (i_last),
        .o_push  (w_push),
        .o_snap  (w_snap_in)
    );

    lac_queue #(
        .SNAP_W(SNAP_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_snap_in),
        .i_pop  (w_pop),
        .o_data (w_snap_out),
        .o_flags(w_qflags)
    );

    lac_back #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_snap           (w_snap_out),
        .i_qflags         (w_qflags),
        .o_pop            (w_pop),
        .i_out_stall      (i_stall),
        .o_valid          (o_valid),
        .o_autocorrelation(o_autocorrelation),
        .o_status         (o_status)
    );

    `CHK_IMPLY(a_push_room, i_clk, i_rst_n, w_push, !w_qflags.full, "series pushed into a full queue")
    `CHK_NEXT(a_push_held, i_clk, i_rst_n, w_push, !w_qflags.empty, "finished series lost from the queue")
    `CHK_IMPLY(a_fault_zero, i_clk, i_rst_n, o_valid && (o_status != lac_pkg::ST_OK), o_autocorrelation == 16'sd0, "flagged result carries a value")

endmodule

// ----- hw/rtl/lac_front.sv -----
// Front end: accepts samples and keeps the running sums of one series.
// Depends on lac_pkg; pushes a snapshot of the series on its last sample.
module lac_front #(
    parameter int MAX_SAMPLES = lac_pkg::MAX_SAMPLES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic signed [15:0]        i_sample,
    input  logic                      i_last,
    output logic                      o_push,
    output logic [lac_pkg::snap_w(lac_pkg::cnt_w(MAX_SAMPLES))-1:0] o_snap
);

    localparam int CW = lac_pkg::cnt_w(MAX_SAMPLES);
    localparam int SW = lac_pkg::sum_w(CW);
    localparam int QW = lac_pkg::sq_w(CW);
    localparam int PW = lac_pkg::prod_w(CW);

    logic [CW-1:0]        r_count, n_count;
    logic signed [SW-1:0] r_sum, n_sum;
    logic [QW-1:0]        r_sq, n_sq;
    logic signed [PW-1:0] r_nb, n_nb;
    logic signed [15:0]   r_first, n_first;
    logic signed [15:0]   r_prev, n_prev;
    logic                 r_ovf, n_ovf;
    logic signed [31:0]   w_sq_term;
    logic signed [31:0]   w_nb_term;

    assign w_sq_term = i_sample * i_sample;
    assign w_nb_term = r_prev * i_sample;

    // Fold the accepted sample into the sums, or mark capacity exceeded
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_sq    = r_sq;
        n_nb    = r_nb;
        n_first = r_first;
        n_prev  = r_prev;
        n_ovf   = r_ovf;
        if (i_accept) begin
            if (r_count < CW'(MAX_SAMPLES)) begin
                if (r_count == '0) begin
                    n_first = i_sample;
                end else begin
                    n_nb = r_nb + PW'(w_nb_term);
                end
                n_sum   = r_sum + SW'(i_sample);
                n_sq    = r_sq + QW'(w_sq_term[30:0]);
                n_prev  = i_sample;
                n_count = r_count + CW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    assign o_push = i_accept && i_last;
    assign o_snap = {n_ovf, n_count, n_first, n_prev, n_nb, n_sq, n_sum};

    // Hold the series state; drop it once the series is handed on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_nb    <= '0;
            r_first <= '0;
            r_prev  <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_sq    <= n_sq;
            r_nb    <= n_nb;
            r_first <= n_first;
            r_prev  <= n_prev;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ----- hw/rtl/lac_queue.sv -----
// Short queue of finished series between the front and back ends.
// Depends on lac_pkg for its depth and flag struct.
module lac_queue #(
    parameter int SNAP_W = lac_pkg::snap_w(lac_pkg::cnt_w(lac_pkg::MAX_SAMPLES_DEF))
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [SNAP_W-1:0]     i_data,
    input  logic                  i_pop,
    output logic [SNAP_W-1:0]     o_data,
    output lac_pkg::t_queue_flags o_flags
);

    localparam int DEPTH = lac_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [SNAP_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_flags.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_flags.empty = (r_cnt == '0);
    assign w_do_push     = i_push && !o_flags.full;
    assign w_do_pop      = i_pop && !o_flags.empty;
    assign o_data        = r_mem[r_rd];

    // Store the pushed snapshot
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/lac_back.sv -----
// Back end: turns a series snapshot into the Q1.15 autocorrelation and status.
// Depends on lac_pkg; one shift-add multiplier and a restoring divider, shared in turn.
module lac_back #(
    parameter int MAX_SAMPLES = lac_pkg::MAX_SAMPLES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lac_pkg::snap_w(lac_pkg::cnt_w(MAX_SAMPLES))-1:0] i_snap,
    input  lac_pkg::t_queue_flags     i_qflags,
    output logic                      o_pop,
    input  logic                      i_out_stall,
    output logic                      o_valid,
    output logic signed [15:0]        o_autocorrelation,
    output logic [1:0]                o_status
);

    localparam int K    = lac_pkg::cnt_w(MAX_SAMPLES);
    localparam int SW   = lac_pkg::sum_w(K);
    localparam int QW   = lac_pkg::sq_w(K);
    localparam int PW   = lac_pkg::prod_w(K);
    localparam int WW   = lac_pkg::wide_w(K);
    localparam int DW   = lac_pkg::div_w(K);
    localparam int MW   = SW;
    localparam int QB   = lac_pkg::QUOT_BITS;
    localparam int DC_W = $clog2(QB + 1);

    lac_pkg::t_back_state r_state, n_state;

    // Unpacked snapshot
    logic                 w_ovf;
    logic [K-1:0]         w_m;
    logic signed [15:0]   w_first;
    logic signed [15:0]   w_prev;
    logic signed [PW-1:0] w_p;
    logic [QW-1:0]        w_q;
    logic signed [SW-1:0] w_s;

    // Series registers
    logic                 r_ovf;
    logic [K-1:0]         r_m;
    logic signed [15:0]   r_first;
    logic signed [15:0]   r_prev;
    logic signed [PW-1:0] r_p;
    logic [QW-1:0]        r_q;
    logic signed [SW-1:0] r_s;
    lac_pkg::t_status     r_status;

    // Intermediate terms
    logic [WW-1:0]        r_s2;
    logic [WW-1:0]        r_b;
    logic [WW-1:0]        r_amag;
    logic                 r_neg;

    // Multiplier and divider
    logic [DW-1:0]        r_ma;
    logic [MW-1:0]        r_mb;
    logic [DW-1:0]        r_acc;
    logic [DW-1:0]        r_den;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_dsh;
    logic [QB-1:0]        r_quot;
    logic [DC_W-1:0]      r_dc;

    // Output register
    logic                 r_out_valid;
    logic [15:0]          r_out_value;
    lac_pkg::t_status     r_out_status;

    logic [SW-1:0]        w_sabs;
    logic signed [31:0]   w_wrap;
    logic                 w_mul_done;
    logic                 w_mul_run;
    logic [WW-1:0]        w_mul_res;
    logic [WW-1:0]        w_diff;
    logic                 w_b_pos;
    logic                 w_ge;
    logic                 w_slot;
    logic                 w_early;
    logic [QB-1:0]        w_nmag;
    logic [QB-1:0]        w_nval;
    logic [15:0]          w_sat;
    logic [15:0]          w_value;

    assign {w_ovf, w_m, w_first, w_prev, w_p, w_q, w_s} = i_snap;

    assign w_sabs     = r_s[SW-1] ? SW'(-r_s) : SW'(r_s);
    assign w_wrap     = r_prev * r_first;
    assign w_mul_done = (r_mb == '0);
    assign w_mul_run  = (r_state inside {lac_pkg::BK_SQ, lac_pkg::BK_MQ, lac_pkg::BK_MP,
                                         lac_pkg::BK_DEN, lac_pkg::BK_NUM}) && !w_mul_done;
    assign w_mul_res  = r_acc[WW-1:0];
    assign w_diff     = w_mul_res - r_s2;
    assign w_b_pos    = !r_b[WW-1] && (r_b != '0);
    assign w_ge       = (r_dsh <= r_rem);
    assign w_slot     = !r_out_valid || !i_out_stall;
    assign w_early    = r_ovf || (r_m < K'(2));
    assign o_pop      = (r_state == lac_pkg::BK_IDLE) && !i_qflags.empty;

    // Clamp the quotient to the Q1.15 range and apply the sign
    assign w_nmag  = (r_quot > QB'(32768)) ? QB'(32768) : r_quot;
    assign w_nval  = QB'(0) - w_nmag;
    assign w_sat   = r_neg ? w_nval[15:0]
                           : ((r_quot > QB'(32767)) ? 16'h7FFF : r_quot[15:0]);
    assign w_value = (r_status == lac_pkg::ST_OK) ? w_sat : 16'h0000;

    // Sequence the steps of one series
    always_comb begin
        n_state = r_state;
        case (r_state)
            lac_pkg::BK_IDLE: begin
                if (!i_qflags.empty) n_state = lac_pkg::BK_WRAP;
            end
            lac_pkg::BK_WRAP: begin
                n_state = w_early ? lac_pkg::BK_OUT : lac_pkg::BK_SQ;
            end
            lac_pkg::BK_SQ: begin
                if (w_mul_done) n_state = lac_pkg::BK_MQ;
            end
            lac_pkg::BK_MQ: begin
                if (w_mul_done) n_state = lac_pkg::BK_MP;
            end
            lac_pkg::BK_MP: begin
                if (w_mul_done) n_state = lac_pkg::BK_CHK;
            end
            lac_pkg::BK_CHK: begin
                n_state = w_b_pos ? lac_pkg::BK_DEN : lac_pkg::BK_OUT;
            end
            lac_pkg::BK_DEN: begin
                if (w_mul_done) n_state = lac_pkg::BK_NUM;
            end
            lac_pkg::BK_NUM: begin
                if (w_mul_done) n_state = lac_pkg::BK_DIV;
            end
            lac_pkg::BK_DIV: begin
                if (r_dc == DC_W'(1)) n_state = lac_pkg::BK_OUT;
            end
            lac_pkg::BK_OUT: begin
                if (w_slot) n_state = lac_pkg::BK_IDLE;
            end
            default: begin
                n_state = lac_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lac_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: load operands, step the multiplier and divider, keep results
    always_ff @(posedge i_clk) begin
        if (w_mul_run) begin
            r_acc <= r_mb[0] ? r_acc + r_ma : r_acc;
            r_ma  <= r_ma << 1;
            r_mb  <= r_mb >> 1;
        end
        case (r_state)
            lac_pkg::BK_IDLE: begin
                if (o_pop) begin
                    r_ovf   <= w_ovf;
                    r_m     <= w_m;
                    r_first <= w_first;
                    r_prev  <= w_prev;
                    r_p     <= w_p;
                    r_q     <= w_q;
                    r_s     <= w_s;
                end
            end
            lac_pkg::BK_WRAP: begin
                // Close the circle with the last-times-first product
                r_p <= r_p + PW'(w_wrap);
                if (r_ovf) begin
                    r_status <= lac_pkg::ST_OVER;
                end else if (r_m < K'(2)) begin
                    r_status <= lac_pkg::ST_FEW;
                end else begin
                    r_status <= lac_pkg::ST_OK;
                end
                r_ma  <= DW'(w_sabs);
                r_mb  <= MW'(w_sabs);
                r_acc <= '0;
            end
            lac_pkg::BK_SQ: begin
                if (w_mul_done) begin
                    r_s2  <= w_mul_res;
                    r_ma  <= DW'(r_q);
                    r_mb  <= MW'(r_m);
                    r_acc <= '0;
                end
            end
            lac_pkg::BK_MQ: begin
                if (w_mul_done) begin
                    r_b   <= w_diff;
                    r_ma  <= DW'(r_p);
                    r_mb  <= MW'(r_m);
                    r_acc <= '0;
                end
            end
            lac_pkg::BK_MP: begin
                if (w_mul_done) begin
                    r_neg  <= w_diff[WW-1];
                    r_amag <= w_diff[WW-1] ? (WW'(0) - w_diff) : w_diff;
                end
            end
            lac_pkg::BK_CHK: begin
                if (!w_b_pos) begin
                    r_status <= lac_pkg::ST_FLAT;
                end
                r_ma  <= DW'(r_b);
                r_mb  <= MW'(r_m);
                r_acc <= '0;
            end
            lac_pkg::BK_DEN: begin
                if (w_mul_done) begin
                    r_den <= r_acc;
                    r_ma  <= DW'(r_amag);
                    r_mb  <= MW'(r_m - K'(1));
                    r_acc <= '0;
                end
            end
            lac_pkg::BK_NUM: begin
                if (w_mul_done) begin
                    r_rem  <= r_acc << lac_pkg::FRAC_BITS;
                    r_dsh  <= r_den << (QB - 1);
                    r_quot <= '0;
                    r_dc   <= DC_W'(QB);
                end
            end
            lac_pkg::BK_DIV: begin
                // One quotient bit per cycle, most significant first
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh  <= r_dsh >> 1;
                r_quot <= {r_quot[QB-2:0], w_ge};
                r_dc   <= r_dc - DC_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Output register: hold a result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == lac_pkg::BK_OUT && w_slot) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lac_pkg::BK_OUT && w_slot) begin
            r_out_value  <= w_value;
            r_out_status <= r_status;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_autocorrelation = r_out_value;
    assign o_status          = r_out_status;

endmodule
